@@ hdl/s2c_pkg.sv @@
// s2c_pkg: types, constants and the control store of the seconds-to-calendar unit.
// Depends on nothing; every other file of the block imports it.
package s2c_pkg;

	// beat payloads
	typedef struct packed {
		logic [31:0] epoch_seconds;
	} s2c_in_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        year_ok;
	} s2c_out_t;

	// calendar constants
	localparam logic [15:0] HOURS_PER_QUAD = 16'd35064;
	localparam logic [13:0] HOURS_PER_YEAR = 14'd8760;
	localparam logic [13:0] HOURS_PER_DAY  = 14'd24;
	localparam logic [7:0]  BASE_YEAR_OFS  = 8'd70;
	localparam logic [11:0] CENTURY_BASE   = 12'd1900;
	localparam logic [11:0] OK_YEAR        = 12'd2000;
	localparam logic [7:0]  OK_YEAR_OFS    = 8'(OK_YEAR - CENTURY_BASE);
	localparam logic [5:0]  SIXTY          = 6'd60;

	// reciprocal constants: q = ((x >> pre) * recip) >> post, exact over the input range
	localparam logic [31:0] RECIP_60   = 32'h8888_8889;  // ceil(2^37 / 60)
	localparam logic [5:0]  POST_60    = 6'd37;
	localparam logic [31:0] RECIP_QUAD = 32'd979915;     // ceil(2^32 / 4383), 35064 = 8 * 4383
	localparam logic [5:0]  POST_QUAD  = 6'd32;
	localparam logic [31:0] RECIP_DAY  = 32'd21846;      // ceil(2^16 / 3), 24 = 8 * 3
	localparam logic [5:0]  POST_DAY   = 6'd16;
	localparam logic [1:0]  PRE_BY8    = 2'd3;

	// microcode op codes
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_MUL   = 3'd1;
	localparam logic [2:0] OP_QREM  = 3'd2;
	localparam logic [2:0] OP_YEAR  = 3'd3;
	localparam logic [2:0] OP_MONTH = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;

	// divisor select
	localparam logic [1:0] DIV_60   = 2'd0;
	localparam logic [1:0] DIV_QUAD = 2'd1;
	localparam logic [1:0] DIV_DAY  = 2'd2;

	// quotient/remainder destination
	localparam logic [1:0] DST_SEC  = 2'd0;
	localparam logic [1:0] DST_MIN  = 2'd1;
	localparam logic [1:0] DST_QUAD = 2'd2;
	localparam logic [1:0] DST_HOUR = 2'd3;

	// jump conditions: taken -> target, else next step
	localparam logic [1:0] COND_NONE     = 2'd0;
	localparam logic [1:0] COND_WAIT_IN  = 2'd1;
	localparam logic [1:0] COND_YEAR     = 2'd2;
	localparam logic [1:0] COND_OUT_BUSY = 2'd3;

	localparam int unsigned STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_YEAR  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

	typedef struct packed {
		logic [2:0]        op;
		logic [1:0]        dsel;
		logic [1:0]        dst;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
	} s2c_ctrl_t;

	typedef struct packed {
		logic year_more;  // remaining hours still cover the current year
		logic out_busy;   // output register full and not taken this cycle
	} s2c_stat_t;

	function automatic s2c_ctrl_t uword(input logic [2:0] op, input logic [1:0] dsel,
			input logic [1:0] dst, input logic [1:0] cond, input logic [STEP_W-1:0] target);
		s2c_ctrl_t w;
		w.op     = op;
		w.dsel   = dsel;
		w.dst    = dst;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic s2c_ctrl_t s2c_ucode(input logic [STEP_W-1:0] step);
		s2c_ctrl_t w;
		unique case (step)
			4'd0:    w = uword(OP_LOAD,  DIV_60,   DST_SEC,  COND_WAIT_IN,  STEP_LOAD);
			4'd1:    w = uword(OP_MUL,   DIV_60,   DST_SEC,  COND_NONE,     STEP_LOAD);
			4'd2:    w = uword(OP_QREM,  DIV_60,   DST_SEC,  COND_NONE,     STEP_LOAD);
			4'd3:    w = uword(OP_MUL,   DIV_60,   DST_MIN,  COND_NONE,     STEP_LOAD);
			4'd4:    w = uword(OP_QREM,  DIV_60,   DST_MIN,  COND_NONE,     STEP_LOAD);
			4'd5:    w = uword(OP_MUL,   DIV_QUAD, DST_QUAD, COND_NONE,     STEP_LOAD);
			4'd6:    w = uword(OP_QREM,  DIV_QUAD, DST_QUAD, COND_NONE,     STEP_LOAD);
			4'd7:    w = uword(OP_YEAR,  DIV_QUAD, DST_QUAD, COND_YEAR,     STEP_YEAR);
			4'd8:    w = uword(OP_MUL,   DIV_DAY,  DST_HOUR, COND_NONE,     STEP_LOAD);
			4'd9:    w = uword(OP_QREM,  DIV_DAY,  DST_HOUR, COND_NONE,     STEP_LOAD);
			4'd10:   w = uword(OP_MONTH, DIV_DAY,  DST_HOUR, COND_NONE,     STEP_LOAD);
			4'd11:   w = uword(OP_EMIT,  DIV_DAY,  DST_HOUR, COND_OUT_BUSY, STEP_LAST);
			default: w = uword(OP_LOAD,  DIV_60,   DST_SEC,  COND_WAIT_IN,  STEP_LOAD);
		endcase
		return w;
	endfunction

	// 0-based first day of month idx (0 = January); February has 29 days in leap years
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] s;
		case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

@@ hdl/s2c_if.sv @@
// s2c_if: valid/ready channel interfaces for the seconds-to-calendar unit.
// Depends on s2c_pkg for the beat payload types.
interface s2c_secs_if;
	import s2c_pkg::*;
	logic    valid;
	logic    ready;
	s2c_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface s2c_cal_if;
	import s2c_pkg::*;
	logic     valid;
	logic     ready;
	s2c_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/seconds_to_calendar_unit.sv @@
// seconds_to_calendar_unit: top level of the seconds-to-calendar converter.
// Depends on s2c_pkg, s2c_if, s2c_seq and s2c_dp.
//
// Usage:
//   secs (sink)  : one beat carries epoch_seconds, a 32-bit count of seconds
//                  since 1970-01-01 00:00:00. Every bit pattern is legal.
//   cal  (source): one beat per input beat with year, month, day, hour,
//                  minute, second and year_ok (year >= 2000). Every year
//                  divisible by four is leap, 2100 included.
// Timing:
//   A microcoded sequencer walks a 12-step program; secs.ready is high only
//   on the first step. The year walk at step 7 repeats while the remaining
//   hours still cover the current year; the rest run once per beat, apart
//   from the waits for input and output. The four divisions (by 60, 60,
//   35064 and 24) share one 32x32 reciprocal multiplier, two steps per
//   division. A new input beat is taken only after the last result has gone into the output register.
// Reset:
//   arst_n clears the step counter and the output valid; no beat is lost
//   or invented afterwards. No clearing pass is needed.
// Stall:
//   The result sits in an output register. If that register is still full
//   and cal.ready is low, the last step waits and the next input beat is
//   not taken until the register is handed over.
module seconds_to_calendar_unit (
	input  logic       clk,
	input  logic       arst_n,
	s2c_secs_if.sink   secs,
	s2c_cal_if.source  cal
);
	import s2c_pkg::*;

	s2c_ctrl_t ctrl;
	s2c_stat_t stat;
	logic      in_fire;

	// input is taken only on the load step
	assign secs.ready = (ctrl.op == OP_LOAD);
	assign in_fire    = secs.valid && secs.ready;

	s2c_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (secs.valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	s2c_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.in_fire (in_fire),
		.in_data (secs.data),
		.stat    (stat),
		.cal     (cal)
	);

endmodule

@@ hdl/s2c_seq.sv @@
// s2c_seq: step counter and control store readout with conditional jumps.
// Depends on s2c_pkg.
module s2c_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  s2c_pkg::s2c_stat_t stat,
	output s2c_pkg::s2c_ctrl_t ctrl
);
	import s2c_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_next;
	logic              jump;

	assign ctrl = s2c_ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:     jump = 1'b0;
			COND_WAIT_IN:  jump = !in_valid;
			COND_YEAR:     jump = stat.year_more;
			COND_OUT_BUSY: jump = stat.out_busy;
			default:       jump = 1'b0;
		endcase
		if (jump) begin
			pc_next = ctrl.target;
		end else if (pc_q == STEP_LAST) begin
			pc_next = STEP_LOAD;
		end else begin
			pc_next = pc_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

@@ hdl/s2c_dp.sv @@
// s2c_dp: datapath - accumulator, shared reciprocal multiplier, year walk,
// month lookup and output register. Depends on s2c_pkg and s2c_cal_if.
module s2c_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  s2c_pkg::s2c_ctrl_t ctrl,
	input  logic               in_fire,
	input  s2c_pkg::s2c_in_t   in_data,
	output s2c_pkg::s2c_stat_t stat,
	s2c_cal_if.source          cal
);
	import s2c_pkg::*;

	logic [31:0] acc_q;
	logic [63:0] prod_q;
	logic [7:0]  yr_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hr_q;
	logic [3:0]  mon_q;
	logic [4:0]  day_q;
	s2c_out_t    out_q;
	logic        out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] quo;
	logic [31:0] qd;
	logic [31:0] rem;
	logic [13:0] ylen;
	logic        leap;
	logic [8:0]  doy0;
	logic [3:0]  midx;
	logic [8:0]  mstart;
	logic        emit_go;

	// operand and quotient selection per divisor
	always_comb begin
		case (ctrl.dsel)
			DIV_QUAD: begin
				mul_a = acc_q >> PRE_BY8;
				mul_b = RECIP_QUAD;
				quo   = 32'(prod_q >> POST_QUAD);
				qd    = 32'(quo * 32'(HOURS_PER_QUAD));
			end
			DIV_DAY: begin
				mul_a = acc_q >> PRE_BY8;
				mul_b = RECIP_DAY;
				quo   = 32'(prod_q >> POST_DAY);
				qd    = 32'(quo * 32'(HOURS_PER_DAY));
			end
			default: begin
				mul_a = acc_q;
				mul_b = RECIP_60;
				quo   = 32'(prod_q >> POST_60);
				qd    = 32'(quo * 32'(SIXTY));
			end
		endcase
		rem = acc_q - qd;
	end

	assign leap = (yr_q[1:0] == 2'b00);
	assign ylen = leap ? (HOURS_PER_YEAR + HOURS_PER_DAY) : HOURS_PER_YEAR;
	assign doy0 = acc_q[8:0];

	// month: last month whose first day is not past the day of year
	always_comb begin
		midx = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (doy0 >= month_start(4'(m), leap)) begin
				midx = 4'(m);
			end
		end
		mstart = month_start(midx, leap);
	end

	assign stat.year_more = (acc_q >= 32'(ylen));
	assign stat.out_busy  = out_valid_q && !cal.ready;
	assign emit_go        = (ctrl.op == OP_EMIT) && !stat.out_busy;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_fire) begin
					acc_q <= in_data.epoch_seconds;
				end
			end
			OP_MUL: begin
				prod_q <= mul_a * mul_b;
			end
			OP_QREM: begin
				unique case (ctrl.dst)
					DST_SEC: begin
						sec_q <= rem[5:0];
						acc_q <= quo;
					end
					DST_MIN: begin
						min_q <= rem[5:0];
						acc_q <= quo;
					end
					DST_QUAD: begin
						acc_q <= rem;
						yr_q  <= BASE_YEAR_OFS + {quo[5:0], 2'b00};
					end
					DST_HOUR: begin
						hr_q  <= rem[4:0];
						acc_q <= quo;
					end
					default: ;
				endcase
			end
			OP_YEAR: begin
				if (stat.year_more) begin
					acc_q <= acc_q - 32'(ylen);
					yr_q  <= yr_q + 8'd1;
				end
			end
			OP_MONTH: begin
				mon_q <= midx + 4'd1;
				day_q <= 5'(doy0 - mstart + 9'd1);
			end
			OP_EMIT: begin
				if (emit_go) begin
					out_q.year    <= 12'(yr_q) + CENTURY_BASE;
					out_q.month   <= mon_q;
					out_q.day     <= day_q;
					out_q.hour    <= hr_q;
					out_q.minute  <= min_q;
					out_q.second  <= sec_q;
					out_q.year_ok <= (yr_q >= OK_YEAR_OFS);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (cal.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cal.valid = out_valid_q;
	assign cal.data  = out_q;

endmodule

@@ hdl/s2c_checker.sv @@
// s2c_checker: port-level assertions for seconds_to_calendar_unit, bound to the top.
// Depends on s2c_pkg.
module s2c_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                secs_valid,
	input logic                secs_ready,
	input logic                cal_valid,
	input logic                cal_ready,
	input s2c_pkg::s2c_out_t   cal_data
);
	import s2c_pkg::*;

	// result beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && !cal_ready |=> cal_valid)
		else $error("cal beat dropped while stalled");

	// one item at a time: no input is taken right after an input beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		secs_valid && secs_ready |=> !secs_ready)
		else $error("input taken twice in a row");

	// calendar fields stay in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (cal_data.month >= 4'd1) && (cal_data.month <= 4'd12) &&
			(cal_data.day >= 5'd1) && (cal_data.hour <= 5'd23) &&
			(cal_data.minute <= 6'd59) && (cal_data.second <= 6'd59))
		else $error("calendar field out of range");

	// year_ok agrees with the year
	a_year_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (cal_data.year_ok == (cal_data.year >= OK_YEAR)))
		else $error("year_ok mismatch");

endmodule

bind seconds_to_calendar_unit s2c_checker u_s2c_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.secs_valid (secs.valid),
	.secs_ready (secs.ready),
	.cal_valid  (cal.valid),
	.cal_ready  (cal.ready),
	.cal_data   (cal.data)
);

@@ tb/sv/seconds_to_calendar_unit_tb.sv @@
`timescale 1ns / 100ps
// seconds_to_calendar_unit_tb: self-checking bench for the seconds-to-calendar unit.
// Depends on s2c_pkg, the s2c_secs_if / s2c_cal_if channels and seconds_to_calendar_unit.
module seconds_to_calendar_unit_tb;
	import s2c_pkg::*;

	// run control
	localparam int unsigned RANDOM_BEATS = 550;
	localparam int unsigned IDLE_LIMIT   = 2000; // cycles with no beat on either side
	localparam int unsigned DRAIN_CYCLES = 20;   // worst program length plus margin
	localparam int unsigned PHASE_LEN    = 300;  // cycles per idling regime
	localparam int unsigned SHOWN_ERRORS = 10;

	// calendar arithmetic
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned MINS_PER_HOUR = 60;
	localparam int unsigned HOURS_PER_DY  = 24;
	localparam int unsigned HOURS_IN_QUAD = 35064;
	localparam int unsigned HOURS_IN_YEAR = 8760;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned YEAR2K        = 2000;

	logic clk;
	logic arst_n;

	s2c_secs_if secs_ch ();
	s2c_cal_if  cal_ch ();

	seconds_to_calendar_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.secs   (secs_ch),
		.cal    (cal_ch)
	);

	logic [31:0] feed_q[$];       // epoch seconds still to be sent
	s2c_out_t    cal_expect_q[$]; // predicted calendar beats, oldest first

	logic        secs_took;       // input beat taken at the last rising edge
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned cyc;
	int unsigned idle_cycles;
	int unsigned err_count;

	// ------------------------------------------------------------------
	// Calendar helpers. The block treats every fourth year as leap,
	// 2100 included, and the bench follows that rule everywhere.
	// ------------------------------------------------------------------
	function automatic bit leap_year(input int unsigned y);
		return (y % 4) == 0;
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input bit leap);
		case (m)
			2:       return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// seconds since the epoch for a calendar date; used to aim stimulus
	// at month and year edges
	function automatic longint seconds_at(input int unsigned y, input int unsigned m,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input int unsigned s);
		longint days;
		int unsigned yy;
		int unsigned mm;
		days = 0;
		for (yy = EPOCH_YEAR; yy < y; yy++) begin
			days += leap_year(yy) ? 366 : 365;
		end
		for (mm = 1; mm < m; mm++) begin
			days += month_days(mm, leap_year(y));
		end
		days += d - 1;
		return ((days * HOURS_PER_DY + h) * MINS_PER_HOUR + mi) * SECS_PER_MIN + s;
	endfunction

	// Predicted beat for one input: peel seconds and minutes, split the hour
	// count into four-year blocks, walk the single years, then the months.
	// An hour count that fills a year exactly lands on 1 January of the next
	// one, and day 60 of a leap year comes out as 29 February.
	function automatic s2c_out_t calendar_of(input logic [31:0] epoch);
		s2c_out_t    c;
		int unsigned t;
		int unsigned hours;
		int unsigned yr;
		int unsigned ylen;
		int unsigned doy;
		int unsigned mon;
		bit          leap;
		t        = epoch;
		c.second = 6'(t % SECS_PER_MIN);
		t        = t / SECS_PER_MIN;
		c.minute = 6'(t % MINS_PER_HOUR);
		hours    = t / MINS_PER_HOUR;
		yr       = EPOCH_YEAR + (hours / HOURS_IN_QUAD) * 4;
		hours    = hours % HOURS_IN_QUAD;
		ylen     = HOURS_IN_YEAR + (leap_year(yr) ? HOURS_PER_DY : 0);
		while (hours >= ylen) begin
			hours -= ylen;
			yr++;
			ylen = HOURS_IN_YEAR + (leap_year(yr) ? HOURS_PER_DY : 0);
		end
		c.hour = 5'(hours % HOURS_PER_DY);
		doy    = hours / HOURS_PER_DY; // 0-based day of year
		leap   = leap_year(yr);
		mon    = 1;
		while (mon < 12 && doy >= month_days(mon, leap)) begin
			doy -= month_days(mon, leap);
			mon++;
		end
		c.month   = 4'(mon);
		c.day     = 5'(doy + 1);
		c.year    = 12'(yr);
		c.year_ok = (yr >= YEAR2K);
		return c;
	endfunction

	function automatic string cal_text(input s2c_out_t c);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d ok=%0d", c.year, c.month, c.day,
			c.hour, c.minute, c.second, c.year_ok);
	endfunction

	// ------------------------------------------------------------------
	// Clock and the single reset at the start of the run
	// ------------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		secs_ch.valid = 1'b0;
		secs_ch.data  = '0;
		cal_ch.ready  = 1'b0;
		fork
			forever #1 clk = ~clk;
			begin
				repeat (6) @(negedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// ------------------------------------------------------------------
	// Input driver: bursts of random length separated by random gaps.
	// In the first regime of every cycle window the gaps are dropped so the
	// block also runs back to back. A beat stays up until it is taken.
	// ------------------------------------------------------------------
	initial begin
		burst_left = 1;
		gap_left   = 0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			secs_ch.valid <= 1'b0;
			secs_ch.data  <= '0;
		end else if (secs_ch.valid && !secs_took) begin
			// beat still waiting for ready: hold it
		end else if (gap_left > 0) begin
			gap_left--;
			secs_ch.valid <= 1'b0;
		end else if (feed_q.size() == 0) begin
			secs_ch.valid <= 1'b0;
		end else begin
			secs_ch.valid              <= 1'b1;
			secs_ch.data.epoch_seconds <= feed_q.pop_front();
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				if ((cyc / PHASE_LEN) % 3 == 0 || $urandom_range(0, 3) == 0) begin
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(1, 25);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side ready: three regimes, chosen in turn by cyc / PHASE_LEN -
	// always ready, random drops, and long stall runs.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			cal_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			case ((cyc / PHASE_LEN) % 3)
				0: begin
					cal_ch.ready <= 1'b1;
				end
				1: begin
					cal_ch.ready <= ($urandom_range(0, 2) != 0);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						cal_ch.ready <= 1'b0;
					end else begin
						cal_ch.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0) begin
							stall_left = $urandom_range(1, 30);
						end
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every input beat, check every result beat against
	// the oldest prediction. Only the first few mismatches are printed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		s2c_out_t got;
		s2c_out_t want;
		if (!arst_n) begin
			secs_took <= 1'b0;
		end else begin
			secs_took <= secs_ch.valid && secs_ch.ready;
			if (secs_ch.valid && secs_ch.ready) begin
				cal_expect_q.push_back(calendar_of(secs_ch.data.epoch_seconds));
			end
			if (cal_ch.valid && cal_ch.ready) begin
				got = cal_ch.data;
				if (cal_expect_q.size() == 0) begin
					err_count++;
					if (err_count <= SHOWN_ERRORS) begin
						$display("%0t: result beat with nothing expected: %s", $realtime,
							cal_text(got));
					end
				end else begin
					want = cal_expect_q.pop_front();
					if (got.year !== want.year || got.month !== want.month
							|| got.day !== want.day || got.hour !== want.hour
							|| got.minute !== want.minute || got.second !== want.second
							|| got.year_ok !== want.year_ok) begin
						err_count++;
						if (err_count <= SHOWN_ERRORS) begin
							$display("%0t: mismatch expected %s actual %s", $realtime,
								cal_text(want), cal_text(got));
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat on either channel restarts the count
	// ------------------------------------------------------------------
	initial begin
		cyc         = 0;
		idle_cycles = 0;
		err_count   = 0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (!arst_n || (secs_ch.valid && secs_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
			$display("FAIL seconds_to_calendar_unit");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		int unsigned y;
		int unsigned m;
		longint      at;

		// directed: range ends, minute/hour/day edges, year rollovers (plain
		// and leap), the leap day itself, the 2000 flag edge and 2100 as leap
		feed_q.push_back(32'd0);
		feed_q.push_back(32'd59);
		feed_q.push_back(32'd60);
		feed_q.push_back(32'd3599);
		feed_q.push_back(32'd86399);
		feed_q.push_back(32'hFFFF_FFFF);
		feed_q.push_back(32'h7FFF_FFFF);
		feed_q.push_back(32'h8000_0000);
		feed_q.push_back(32'(seconds_at(1970, 12, 31, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(1971, 1, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(1972, 2, 28, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(1972, 2, 29, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(1972, 2, 29, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(1972, 3, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(1972, 12, 31, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(1973, 1, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(1973, 12, 31, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(1974, 1, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(1999, 12, 31, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(2000, 1, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(2100, 2, 28, 12, 0, 0)));
		feed_q.push_back(32'(seconds_at(2100, 2, 29, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(2100, 3, 1, 0, 0, 0)));
		feed_q.push_back(32'(seconds_at(2100, 12, 31, 23, 59, 59)));
		feed_q.push_back(32'(seconds_at(2106, 1, 1, 0, 0, 0)));

		// random: uniform patterns mixed with values aimed at year ends,
		// the end of February and month starts, where the walks turn over
		for (n = 0; n < RANDOM_BEATS; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					at = $urandom;
				end
				4, 5, 6: begin
					y  = $urandom_range(1971, 2106);
					at = seconds_at(y, 1, 1, 0, 0, 0) + $urandom_range(0, 7200) - 3600;
				end
				7, 8: begin
					y  = $urandom_range(1970, 2105);
					at = seconds_at(y, 2, 28, 0, 0, 0) + $urandom_range(0, 3 * 86400 - 1);
				end
				default: begin
					y  = $urandom_range(1970, 2105);
					m  = $urandom_range(1, 12);
					at = seconds_at(y, m, 1, 0, 0, 0) + $urandom_range(0, 4 * 86400)
						- 2 * 86400;
				end
			endcase
			feed_q.push_back(32'(at)); // below 1970 wraps to the top of the range
		end

		@(posedge arst_n);
		while (feed_q.size() != 0 || secs_ch.valid || cal_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		err_count += cal_expect_q.size();

		if (err_count == 0) begin
			$display("PASS seconds_to_calendar_unit");
		end else begin
			$display("FAIL seconds_to_calendar_unit");
		end
		$finish;
	end

endmodule
